### hdl/blr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blr_pkg
// Types, constants and helpers shared by the byte-lane realignment buffer.
// ---------------------------------------------------------------------------
package blr_pkg;

    localparam int LANES_DEF = 8;
    localparam int DEPTH_DEF = 4;
    localparam int BUS_BYTES = 8;
    localparam int HELD_W    = 6;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_e;

    typedef struct packed {
        cmd_e        cmd;
        logic        same_cycle;
        logic [7:0]  mask;
        logic [2:0]  shift;
        logic [63:0] data_in;
    } req_item_t;

    typedef struct packed {
        logic        accepted;
        logic [63:0] data_out;
        logic [5:0]  bytes_held;
    } rsp_item_t;

    // beat decision handed from the controller to the result stage
    typedef struct packed {
        logic        ok;
        logic        pop;
        logic [7:0]  mask;
        logic [2:0]  shift;
        logic [5:0]  held;
    } blr_dec_t;

    // (idx + shift) mod lanes for idx < lanes, lanes from 1 to 8
    function automatic logic [3:0] lane_rot(input logic [3:0] idx,
                                            input logic [2:0] shift,
                                            input logic [3:0] lanes);
        logic [3:0] v;
        v = idx + {1'b0, shift};
        for (int k = 0; k < 8; k++)
        begin
            if (v >= lanes)
            begin
                v = v - lanes;
            end
        end
        return v;
    endfunction

endpackage

### hdl/blr_lane_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blr_lane_mem
// One byte lane of storage: single write port, registered read port.
// ---------------------------------------------------------------------------
module blr_lane_mem
    import blr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/blr_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blr_ctrl
// Lane bookkeeping: heads, fill counts, same-cycle push flags and the byte
// total; judges each beat and drives the lane memory ports.
// ---------------------------------------------------------------------------
module blr_ctrl
    import blr_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  req_item_t     req,
    output logic          mem_we    [LANES],
    output logic [AW-1:0] mem_waddr [LANES],
    output logic [7:0]    mem_wdata [LANES],
    output logic          mem_re    [LANES],
    output logic [AW-1:0] mem_raddr [LANES],
    output blr_dec_t      dec
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int TW = $clog2(LANES * DEPTH + 1);
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic [AW-1:0] head_reg [LANES];
    logic [AW-1:0] head_next [LANES];
    logic [CW-1:0] cnt_reg [LANES];
    logic [CW-1:0] cnt_next [LANES];
    logic [LANES-1:0] lpn_reg, lpn_next;
    logic          pt_reg, pt_next;
    logic [TW-1:0] total_reg, total_next;

    logic [LANES-1:0] lpn_eff, full, vis, push_en, pop_en;
    logic          pt_eff, push_ok, pop_ok, ok, is_pop, do_push, do_pop;
    logic [TW-1:0] nbytes;

    always_comb
    begin
        logic [3:0] l_src;
        pt_eff = req.same_cycle & pt_reg;
        is_pop = (req.cmd == CMD_POP);
        nbytes = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lpn_eff[l] = req.same_cycle & lpn_reg[l];
            full[l]    = (cnt_reg[l] == CW'(DEPTH));
            vis[l]     = (cnt_reg[l] != '0) && !(lpn_eff[l] && cnt_reg[l] == CW'(1));
            push_en[l] = req.mask[l];
            nbytes     = nbytes + TW'(req.mask[l]);
        end
        pop_en = '0;
        for (int j = 0; j < LANES; j++)
        begin
            l_src = lane_rot(4'(j), req.shift, 4'(LANES));
            if (req.mask[j])
            begin
                pop_en[l_src[LW-1:0]] = 1'b1;
            end
        end
        push_ok = !pt_eff && ((push_en & full) == '0);
        pop_ok  = ((pop_en & ~vis) == '0);
        ok      = is_pop ? pop_ok : push_ok;
        do_push = fire && !is_pop && ok;
        do_pop  = fire && is_pop && ok;
    end

    // memory ports
    always_comb
    begin
        logic [SW-1:0] slot;
        logic [3:0]    src;
        for (int l = 0; l < LANES; l++)
        begin
            slot = SW'(head_reg[l]) + SW'(cnt_reg[l]);
            if (slot >= SW'(DEPTH))
            begin
                slot = slot - SW'(DEPTH);
            end
            src           = lane_rot(4'(l), req.shift, 4'(LANES));
            mem_we[l]     = do_push && push_en[l];
            mem_waddr[l]  = AW'(slot);
            mem_wdata[l]  = req.data_in[8*src[2:0] +: 8];
            mem_re[l]     = do_pop && pop_en[l];
            mem_raddr[l]  = head_reg[l];
        end
    end

    // bookkeeping next values
    always_comb
    begin
        pt_next    = pt_reg;
        lpn_next   = lpn_reg;
        total_next = total_reg;
        for (int l = 0; l < LANES; l++)
        begin
            head_next[l] = head_reg[l];
            cnt_next[l]  = cnt_reg[l];
        end
        if (fire)
        begin
            pt_next  = pt_eff | do_push;
            lpn_next = lpn_eff | ({LANES{do_push}} & push_en);
            if (do_push)
            begin
                total_next = total_reg + nbytes;
            end
            else if (do_pop)
            begin
                total_next = total_reg - nbytes;
            end
            for (int l = 0; l < LANES; l++)
            begin
                if (do_push && push_en[l])
                begin
                    cnt_next[l] = cnt_reg[l] + CW'(1);
                end
                else if (do_pop && pop_en[l])
                begin
                    cnt_next[l]  = cnt_reg[l] - CW'(1);
                    head_next[l] = (head_reg[l] == AW'(DEPTH - 1)) ? '0
                                                                   : head_reg[l] + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg    <= 1'b0;
            lpn_reg   <= '0;
            total_reg <= '0;
            for (int l = 0; l < LANES; l++)
            begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            pt_reg    <= pt_next;
            lpn_reg   <= lpn_next;
            total_reg <= total_next;
            for (int l = 0; l < LANES; l++)
            begin
                head_reg[l] <= head_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
        end
    end

    always_comb
    begin
        dec.ok    = ok;
        dec.pop   = is_pop;
        dec.mask  = req.mask;
        dec.shift = req.shift;
        dec.held  = HELD_W'(total_next);
    end

endmodule

### hdl/byte_lane_realign_fifo_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_lane_realign_fifo_top
// Byte-lane realignment buffer: LANES per-lane byte FIFOs with rotated
// push and pop beats and all-or-nothing acceptance.
// ---------------------------------------------------------------------------
// Each beat produces one result item: the beat is judged and the lane
// memories are written or read in the accept cycle, and the registered
// read data of the lane memories is assembled into the result register
// once that register is empty or being drained. A new beat is taken only
// after the previous one was loaded there. Lane memories need no clearing
// after reset since a lane entry is only ever read after it was pushed.
// ---------------------------------------------------------------------------
module byte_lane_realign_fifo_top
    import blr_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic          mem_we    [LANES];
    logic [AW-1:0] mem_waddr [LANES];
    logic [7:0]    mem_wdata [LANES];
    logic          mem_re    [LANES];
    logic [AW-1:0] mem_raddr [LANES];
    logic [7:0]    mem_rdata [LANES];

    blr_dec_t  dec, dec_reg;
    logic      pend_reg, pend_next;
    logic      out_valid_reg, out_valid_next;
    rsp_item_t rsp_reg, rsp_next;
    logic      fire, load;

    assign req_ready = !pend_reg;
    assign fire      = req_valid && req_ready;
    assign load      = pend_reg && (!out_valid_reg || rsp_ready);

    blr_ctrl #(
        .LANES (LANES),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .dec       (dec)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        blr_lane_mem #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_mem (
            .clk   (clk),
            .we    (mem_we[l]),
            .waddr (mem_waddr[l]),
            .wdata (mem_wdata[l]),
            .re    (mem_re[l]),
            .raddr (mem_raddr[l]),
            .rdata (mem_rdata[l])
        );
    end

    // result assembly from the lane read data
    always_comb
    begin
        logic [3:0] lane;
        rsp_next.accepted   = dec_reg.ok;
        rsp_next.bytes_held = dec_reg.held;
        rsp_next.data_out   = '0;
        for (int j = 0; j < BUS_BYTES; j++)
        begin
            lane = lane_rot(4'(j % LANES), dec_reg.shift, 4'(LANES));
            if (j < LANES && dec_reg.ok && dec_reg.pop && dec_reg.mask[j])
            begin
                rsp_next.data_out[8*j +: 8] = mem_rdata[lane[LW-1:0]];
            end
        end
    end

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (fire)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dec_reg <= dec;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/blr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blr_checker
// Port-level checks for the byte-lane realignment buffer.
// ---------------------------------------------------------------------------
module blr_checker
    import blr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    logic [1:0] open_reg, open_next;
    logic       seen_reg;
    logic [5:0] held_reg;
    logic       req_fire, rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        open_next = open_reg;
        if (req_fire && !rsp_fire)
        begin
            open_next = open_reg + 2'd1;
        end
        else if (rsp_fire && !req_fire)
        begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            seen_reg <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
            if (rsp_fire)
            begin
                seen_reg <= 1'b1;
                held_reg <= rsp.bytes_held;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted |-> rsp.data_out == 64'd0)
        else $error("refused item carries data");

    a_refused_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted && seen_reg |-> rsp.bytes_held == held_reg)
        else $error("refused item changed the byte count");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("result without an outstanding item");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("too many items in flight");

endmodule

bind byte_lane_realign_fifo_top blr_checker u_blr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
